// ===== rtl/core/bst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants
// Sizes, register addresses, opcodes and sequencer states of the sighting table.
// ----------------------------------------------------------------------------
package bst_pkg;
	localparam int SIGHTING_SLOTS = 16;
	localparam int TAG_SLOTS      = 8;
	localparam int SW             = $clog2(SIGHTING_SLOTS);
	localparam int TW             = $clog2(TAG_SLOTS);
	localparam logic signed [7:0] RSSI_NONE = -8'sd127;

	localparam logic [3:0] ADDR_SIGHT_FRESH = 4'h0;
	localparam logic [3:0] ADDR_TAG_FRESH   = 4'h4;
	localparam logic [3:0] ADDR_DEF_MIN     = 4'h8;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ADV   = 2'd1,
		OP_WRITE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_OLDEST,
		ST_STORE,
		ST_TAGS,
		ST_COUNT,
		ST_DONE
	} state_t;

	// control from sequencer to the shared compare unit
	typedef struct packed {
		logic clr;
		logic age_sel;
	} cmp_ctl_t;
endpackage

// ===== rtl/core/bst_age_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_age_cmp: shared time compare unit
// Wrapping age test or raw less-than on 32-bit times, one pair per cycle.
// ----------------------------------------------------------------------------
module bst_age_cmp (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] limit,
	output logic        in_window,
	output logic        less
);
	logic [31:0] age;

	// take wrapping age and compare against window, and raw less-than of a and b
	always_comb begin
		age       = a - b;
		in_window = age <= limit;
		less      = a < b;
	end
endmodule

// ===== rtl/core/beacon_sighting_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_sighting_table_top: beacon sighting table with tag tracking
// Sequencer walks sighting and tag slots through one shared compare unit.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// request   | start & !busy        | opcode, adv_*, tag_*
// result    | done (one cycle)     | counts, stored_*, tag_present, tag_rssi
// config    | psel&penable&pwrite  | paddr, pwdata, prdata
// An advertisement raises done after a find walk, an oldest walk, a store, a
// tag walk, a count walk and the done state; a request that finds its slot or
// a free slot skips the oldest walk. Other requests raise done after the count
// walk and the done state. busy drops in the done cycle, so the next request
// can be taken at the edge that ends it.
// Reset clears valid bits and sets tag state and config registers to defaults. The receiver cannot stall.
module beacon_sighting_table_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [47:0]        adv_address,
	input  logic signed [7:0]  adv_rssi,
	input  logic [2:0]         tag_slot,
	input  logic [47:0]        tag_address,
	input  logic signed [7:0]  tag_min_rssi,
	output logic               done,
	output logic [4:0]         fresh_sighting_count,
	output logic [3:0]         present_tag_count,
	output logic               stored_flag,
	output logic [3:0]         stored_slot,
	output logic [3:0]         matched_tag_count,
	output logic               tag_present,
	output logic signed [7:0]  tag_rssi,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bst_pkg::*;

	state_t state_q, state_d;
	logic [31:0] sfresh_q, tfresh_q, now_q;
	logic signed [7:0] defmin_q;
	logic [SIGHTING_SLOTS-1:0] sv_q;
	logic [47:0] saddr_q [SIGHTING_SLOTS];
	logic signed [7:0] srssi_q [SIGHTING_SLOTS];
	logic [31:0] stime_q [SIGHTING_SLOTS];
	logic [TAG_SLOTS-1:0] tv_q;
	logic [47:0] taddr_q [TAG_SLOTS];
	logic signed [7:0] tmin_q [TAG_SLOTS];
	logic signed [7:0] tlast_q [TAG_SLOTS];
	logic [31:0] ttime_q [TAG_SLOTS];

	logic [1:0] op_q;
	logic [47:0] aaddr_q;
	logic signed [7:0] arssi_q;
	logic [2:0] ts_q;
	logic [SW:0] idx_q;
	logic [SW-1:0] slot_q;
	logic found_q, free_q;
	logic [4:0] fresh_q;
	logic [3:0] pres_q, match_q;
	logic tp_q;
	logic signed [7:0] tr_q;

	logic [31:0] cmp_a, cmp_b, cmp_lim;
	logic in_window, less;
	cmp_ctl_t ctl;
	logic [SW-1:0] si;
	logic [TW-1:0] ti;
	logic ts_ok;

	assign pready = 1'b1;
	assign busy   = state_q != ST_IDLE;
	assign si     = idx_q[SW-1:0];
	assign ti     = idx_q[TW-1:0];
	assign ts_ok  = {1'b0, ts_q} < 4'(TAG_SLOTS);

	// read back registers
	always_comb begin
		case (paddr)
			ADDR_SIGHT_FRESH: prdata = sfresh_q;
			ADDR_TAG_FRESH:   prdata = tfresh_q;
			ADDR_DEF_MIN:     prdata = {{24{defmin_q[7]}}, defmin_q};
			default:          prdata = '0;
		endcase
	end

	// route operands to shared compare unit
	always_comb begin
		ctl.clr     = state_q == ST_OLDEST;
		ctl.age_sel = idx_q < (SW+1)'(SIGHTING_SLOTS);
		cmp_a   = now_q;
		cmp_b   = stime_q[si];
		cmp_lim = sfresh_q;
		if (ctl.clr) begin
			cmp_a = stime_q[si];
			cmp_b = stime_q[slot_q];
		end else if (state_q == ST_COUNT && !ctl.age_sel) begin
			cmp_b   = ttime_q[ti];
			cmp_lim = tfresh_q;
		end
	end

	bst_age_cmp u_cmp (
		.a         (cmp_a),
		.b         (cmp_b),
		.limit     (cmp_lim),
		.in_window (in_window),
		.less      (less)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) begin
				if (op_t'(opcode) == OP_ADV) state_d = ST_FIND;
				else state_d = ST_COUNT;
			end
			ST_FIND:   if (found_q || idx_q == (SW+1)'(SIGHTING_SLOTS-1))
				state_d = (found_q || free_q || !sv_q[si] ||
					(sv_q[si] && saddr_q[si] == aaddr_q)) ? ST_STORE : ST_OLDEST;
			ST_OLDEST: if (idx_q == (SW+1)'(SIGHTING_SLOTS-1)) state_d = ST_STORE;
			ST_STORE:  state_d = ST_TAGS;
			ST_TAGS:   if (idx_q == (SW+1)'(TAG_SLOTS-1)) state_d = ST_COUNT;
			ST_COUNT:  if (idx_q == (SW+1)'(SIGHTING_SLOTS+TAG_SLOTS-1))
				state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfresh_q <= 32'd30000;
			tfresh_q <= 32'd60000;
			defmin_q <= -8'sd90;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_SIGHT_FRESH: sfresh_q <= pwdata;
				ADDR_TAG_FRESH:   tfresh_q <= pwdata;
				ADDR_DEF_MIN:     defmin_q <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	// sighting payload store
	always_ff @(posedge clk) begin
		if (state_q == ST_STORE) begin
			saddr_q[slot_q] <= aaddr_q;
			srssi_q[slot_q] <= arssi_q;
			stime_q[slot_q] <= now_q;
		end
	end

	// latch request and walk slots
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q    <= opcode;
			aaddr_q <= adv_address;
			arssi_q <= adv_rssi;
			ts_q    <= tag_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			sv_q    <= '0;
			tv_q    <= '0;
			idx_q   <= '0;
			slot_q  <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			fresh_q <= '0;
			pres_q  <= '0;
			match_q <= '0;
			tp_q    <= 1'b0;
			tr_q    <= RSSI_NONE;
			done    <= 1'b0;
			for (int i = 0; i < TAG_SLOTS; i++) begin
				taddr_q[i] <= '0;
				tmin_q[i]  <= -8'sd90;
				tlast_q[i] <= RSSI_NONE;
				ttime_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					idx_q   <= '0;
					found_q <= 1'b0;
					free_q  <= 1'b0;
					slot_q  <= '0;
					fresh_q <= '0;
					pres_q  <= '0;
					match_q <= '0;
					tp_q    <= 1'b0;
					tr_q    <= RSSI_NONE;
					// apply tick, write and clear at once
					if (op_t'(opcode) == OP_TICK) now_q <= now_q + 32'd1;
					else if (op_t'(opcode) != OP_ADV &&
						{1'b0, tag_slot} < 4'(TAG_SLOTS)) begin
						tv_q[tag_slot[TW-1:0]]    <= op_t'(opcode) == OP_WRITE;
						taddr_q[tag_slot[TW-1:0]] <=
							op_t'(opcode) == OP_WRITE ? tag_address : 48'd0;
						tmin_q[tag_slot[TW-1:0]]  <=
							op_t'(opcode) == OP_WRITE ? tag_min_rssi : defmin_q;
						tlast_q[tag_slot[TW-1:0]] <= RSSI_NONE;
						ttime_q[tag_slot[TW-1:0]] <= '0;
					end
				end
				// hold first match, else first free slot
				ST_FIND: if (!found_q) begin
					if (sv_q[si] && saddr_q[si] == aaddr_q) begin
						found_q <= 1'b1;
						slot_q  <= si;
					end else if (!sv_q[si] && !free_q) begin
						free_q <= 1'b1;
						slot_q <= si;
					end
					if (state_d != ST_FIND) idx_q <= '0;
					else idx_q <= idx_q + (SW+1)'(1);
				end
				// keep strictly smaller time, lowest index wins ties
				ST_OLDEST: begin
					if (less) slot_q <= si;
					idx_q <= idx_q + (SW+1)'(1);
				end
				ST_STORE: begin
					sv_q[slot_q] <= 1'b1;
					idx_q <= '0;
				end
				ST_TAGS: begin
					if (tv_q[ti] && taddr_q[ti] == aaddr_q && arssi_q >= tmin_q[ti]) begin
						tlast_q[ti] <= arssi_q;
						ttime_q[ti] <= now_q;
						match_q     <= match_q + 4'd1;
					end
					idx_q <= (state_d == ST_TAGS) ? idx_q + (SW+1)'(1) : '0;
				end
				// count fresh sightings, then present tags and capture the selected tag's RSSI
				ST_COUNT: begin
					if (ctl.age_sel) begin
						if (sv_q[si] && in_window) fresh_q <= fresh_q + 5'd1;
					end else if (tv_q[ti] && in_window) begin
						pres_q <= pres_q + 4'd1;
						if (ts_ok && ti == ts_q[TW-1:0]) begin
							tp_q <= 1'b1;
							tr_q <= tlast_q[ti];
						end
					end
					idx_q <= idx_q + (SW+1)'(1);
				end
				ST_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	assign fresh_sighting_count = fresh_q;
	assign present_tag_count    = pres_q;
	assign stored_flag          = op_t'(op_q) == OP_ADV;
	assign stored_slot          = stored_flag ? 4'(slot_q) : 4'd0;
	assign matched_tag_count    = match_q;
	assign tag_present          = tp_q;
	assign tag_rssi             = tr_q;

`ifndef SYNTH
	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> matched_tag_count <= 4'(TAG_SLOTS)) else $error("match overflow");
`endif
endmodule
